// ===== src/dic_pkg.sv =====
`default_nettype none
package dic_pkg;

	localparam logic [2:0] OP_READ  = 3'd0;
	localparam logic [2:0] OP_WRITE = 3'd1;
	localparam logic [2:0] OP_ACK   = 3'd2;
	localparam logic [2:0] OP_RAISE = 3'd3;
	localparam logic [2:0] OP_DROP  = 3'd4;

	localparam logic [7:0] NO_READ      = 8'hff;
	localparam logic [7:0] OCW3_RESET   = 8'h0a;
	localparam logic [7:0] MASK_RESET   = 8'hff;
	localparam logic [7:0] POLL_FLAG    = 8'h80;
	localparam logic [7:0] VECTOR_MASK  = 8'hf8;
	localparam logic [2:0] DEFAULT_LEVEL = 3'd7;

	typedef enum logic [1:0] {
		PH_ICW2  = 2'd0,
		PH_ICW3  = 2'd1,
		PH_ICW4  = 2'd2,
		PH_READY = 2'd3
	} phase_t;

	typedef struct packed {
		logic [2:0] op;
		logic       controller;
		logic       reg_select;
		logic [7:0] write_data;
		logic [2:0] irq_line;
	} cmd_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic [7:0] vector_out;
		logic       int_request;
	} rsp_t;

	// Per-controller decoded request, valid only for the cycle the item executes.
	typedef struct packed {
		logic       wr;
		logic       raise;
		logic       drop;
		logic       ack;
		logic       a0;
		logic [7:0] data;
		logic [2:0] line;
		logic [2:0] ack_level;
	} ctrl_cmd_t;

	typedef struct packed {
		logic [7:0] irr;
		logic [7:0] imr;
		logic [7:0] irr_nxt;
		logic [7:0] imr_nxt;
		logic [7:0] rd_data;
		logic [7:0] vbase;
		logic       refresh;
	} ctrl_stat_t;

	// Index of the lowest set bit; zero when none is set.
	function automatic logic [2:0] lowest_bit(input logic [7:0] v);
		logic [2:0] idx;
		idx = 3'd0;
		for (int i = 7; i >= 0; i--) begin
			if (v[i]) begin
				idx = 3'(i);
			end
		end
		return idx;
	endfunction

endpackage
`default_nettype wire

// ===== src/dic_chan_if.sv =====
`default_nettype none
interface dic_chan_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== src/dic_ctrl.sv =====
`default_nettype none
module dic_ctrl
	import dic_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire ctrl_cmd_t  cmd,
	output ctrl_stat_t      stat
);

	logic [7:0] icw1_q, icw2_q, imr_q, ocw3_q, irr_q, isr_q;
	phase_t     phase_q;

	logic [7:0] icw1_d, icw2_d, imr_d, ocw3_d, irr_d, isr_d;
	phase_t     phase_d;
	logic       refresh;
	logic [7:0] rd_data;

	always_comb begin
		icw1_d  = icw1_q;
		icw2_d  = icw2_q;
		imr_d   = imr_q;
		ocw3_d  = ocw3_q;
		irr_d   = irr_q;
		isr_d   = isr_q;
		phase_d = phase_q;
		refresh = 1'b0;
		if (cmd.wr && !cmd.a0) begin
			if (cmd.data[4]) begin
				icw1_d  = cmd.data;
				phase_d = PH_ICW2;
				irr_d   = '0;
				isr_d   = '0;
			end else if (cmd.data[4:3] == 2'b00) begin
				// Any OCW2 acts as a non-specific end of interrupt.
				irr_d   = irr_q & ~isr_q;
				isr_d   = '0;
				refresh = 1'b1;
			end else begin
				ocw3_d = cmd.data;
			end
		end else if (cmd.wr) begin
			unique case (phase_q)
				PH_ICW2: begin
					icw2_d  = cmd.data;
					phase_d = icw1_q[1] ? PH_ICW4 : PH_ICW3;
				end
				PH_ICW3: begin
					phase_d = PH_ICW4;
				end
				PH_ICW4: begin
					phase_d = PH_READY;
					if (!icw1_q[0]) begin
						imr_d   = cmd.data;
						refresh = 1'b1;
					end
				end
				PH_READY: begin
					imr_d   = cmd.data;
					refresh = 1'b1;
				end
				default: begin
					phase_d = phase_q;
				end
			endcase
		end
		if (cmd.raise) begin
			irr_d   = irr_q | (8'd1 << cmd.line);
			refresh = 1'b1;
		end
		if (cmd.drop) begin
			irr_d   = irr_q & ~(8'd1 << cmd.line);
			refresh = 1'b1;
		end
		if (cmd.ack) begin
			isr_d = 8'd1 << cmd.ack_level;
		end
	end

	always_comb begin
		if (cmd.a0) begin
			rd_data = imr_q;
		end else if (ocw3_q[2]) begin
			rd_data = (irr_q == '0) ? 8'h00 : (POLL_FLAG | {5'd0, lowest_bit(irr_q)});
		end else if (ocw3_q[1]) begin
			rd_data = ocw3_q[0] ? isr_q : irr_q;
		end else begin
			rd_data = NO_READ;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			icw1_q  <= '0;
			icw2_q  <= '0;
			imr_q   <= MASK_RESET;
			ocw3_q  <= OCW3_RESET;
			irr_q   <= '0;
			isr_q   <= '0;
			phase_q <= PH_ICW2;
		end else begin
			icw1_q  <= icw1_d;
			icw2_q  <= icw2_d;
			imr_q   <= imr_d;
			ocw3_q  <= ocw3_d;
			irr_q   <= irr_d;
			isr_q   <= isr_d;
			phase_q <= phase_d;
		end
	end

	assign stat.irr     = irr_q;
	assign stat.imr     = imr_q;
	assign stat.irr_nxt = irr_d;
	assign stat.imr_nxt = imr_d;
	assign stat.rd_data = rd_data;
	assign stat.vbase   = icw2_q;
	assign stat.refresh = refresh;

endmodule
`default_nettype wire

// ===== src/dual_interrupt_controller_core.sv =====
// Pair of cascaded 8259A-style interrupt controllers behind one processor line.
// Channel cmd (sink) takes one item per handshake: a register read or write, an
// interrupt acknowledge, or a raise or drop of one request line on one controller.
// Channel rsp (source) returns exactly one item per command, in order: the read
// byte (0xff when the item is not a read), the acknowledge vector (zero
// otherwise) and the state of the interrupt line after the command.
// An accepted command is held in an input register, executes against the
// controller state from there and lands in the response register. One
// command per cycle is sustained while rsp is taken; the 16-line priority
// scan sits between the input register and the response register.
// When the receiver stalls, the response register holds and the input register
// fills; cmd.ready then drops until rsp is taken. cmd.ready depends on rsp.ready.
// Asynchronous reset clears both pipeline stages, masks all lines, selects the
// request register for command reads and restarts initialization on both
// controllers.
`default_nettype none
module dual_interrupt_controller_core
	import dic_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	dic_chan_if.sink   cmd,
	dic_chan_if.source rsp
);

	logic       valid_s1;
	cmd_t       cmd_s1;
	logic       rsp_valid_q;
	rsp_t       rsp_q;
	logic       int_line_q;

	logic       out_free;
	logic       fire_s1;
	ctrl_cmd_t  ccmd [2];
	ctrl_stat_t cstat [2];

	logic [7:0] pend0, pend1;
	logic       ack_ctrl;
	logic [2:0] ack_level;
	logic [7:0] vector;
	logic       int_line_d;
	rsp_t       rsp_d;

	assign out_free  = !rsp_valid_q || rsp.ready;
	assign fire_s1   = valid_s1 && out_free;
	assign cmd.ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			cmd_s1 <= cmd.payload;
		end
	end

	// Acknowledge scans controller 0 lines first, then controller 1.
	assign pend0 = cstat[0].irr & ~cstat[0].imr;
	assign pend1 = cstat[1].irr & ~cstat[1].imr;

	always_comb begin
		if (pend0 != '0) begin
			ack_ctrl  = 1'b0;
			ack_level = lowest_bit(pend0);
		end else if (pend1 != '0) begin
			ack_ctrl  = 1'b1;
			ack_level = lowest_bit(pend1);
		end else begin
			ack_ctrl  = 1'b0;
			ack_level = DEFAULT_LEVEL;
		end
		vector = (cstat[ack_ctrl].vbase & VECTOR_MASK) | {5'd0, ack_level};
	end

	for (genvar c = 0; c < 2; c++) begin : g_ctrl
		logic sel;
		assign sel = fire_s1 && (cmd_s1.controller == 1'(c));
		assign ccmd[c].wr        = sel && (cmd_s1.op == OP_WRITE);
		assign ccmd[c].raise     = sel && (cmd_s1.op == OP_RAISE);
		assign ccmd[c].drop      = sel && (cmd_s1.op == OP_DROP);
		assign ccmd[c].ack       = fire_s1 && (cmd_s1.op == OP_ACK) && (ack_ctrl == 1'(c));
		assign ccmd[c].a0        = cmd_s1.reg_select;
		assign ccmd[c].data      = cmd_s1.write_data;
		assign ccmd[c].line      = cmd_s1.irq_line;
		assign ccmd[c].ack_level = ack_level;

		dic_ctrl u_ctrl (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (ccmd[c]),
			.stat   (cstat[c])
		);
	end

	always_comb begin
		int_line_d = int_line_q;
		if (cmd_s1.op == OP_ACK) begin
			int_line_d = 1'b0;
		end else if (cstat[0].refresh || cstat[1].refresh) begin
			int_line_d = ((cstat[0].irr_nxt & ~cstat[0].imr_nxt) != '0) ||
				((cstat[1].irr_nxt & ~cstat[1].imr_nxt) != '0);
		end
		rsp_d.read_data   = (cmd_s1.op == OP_READ) ? cstat[cmd_s1.controller].rd_data
			: NO_READ;
		rsp_d.vector_out  = (cmd_s1.op == OP_ACK) ? vector : 8'h00;
		rsp_d.int_request = int_line_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			int_line_q  <= 1'b0;
		end else begin
			if (out_free) begin
				rsp_valid_q <= valid_s1;
			end
			if (fire_s1) begin
				int_line_q <= int_line_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp.valid   = rsp_valid_q;
	assign rsp.payload = rsp_q;

	a_ack_drops_line: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && cmd_s1.op == OP_ACK) |=> (!int_line_q && !rsp_q.int_request))
		else $error("interrupt line not dropped after acknowledge");

	a_nonread_ff: assert property (@(posedge clk) disable iff (!arst_n)
		(fire_s1 && cmd_s1.op != OP_READ) |=> (rsp_q.read_data == NO_READ))
		else $error("non-read item returned read data");

	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !out_free) |=> (valid_s1 && $stable(cmd_s1)))
		else $error("stalled item lost from input register");

	a_line_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 |=> (rsp_q.int_request == int_line_q))
		else $error("response line differs from stored line");

endmodule
`default_nettype wire
